// ----- sv/yrbc_pkg.sv -----
// Shared constants, types and sizes for the YUYV red blob centroid block.
`timescale 1ns / 1ps
`default_nettype none
package yrbc_pkg;

  // Window limits and the widths that follow from them
  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int ADDR_W      = COL_W - 1;
  localparam int LINE_DEPTH  = MAX_COLUMNS / 2;

  // Field widths
  localparam int PIX_W      = 8;
  localparam int CFG_SIZE_W = 11;
  localparam int CFG_DATA_W = 11;
  localparam int COUNT_W    = 21;
  localparam int SUM_W      = 30;

  // Compare width wide enough for the size registers and for the limits
  localparam int DIM_W  = (COL_W > ROW_W) ? COL_W + 1 : ROW_W + 1;
  localparam int SIZE_W = (DIM_W > CFG_SIZE_W) ? DIM_W : CFG_SIZE_W;

  localparam int MIN_COLUMNS = 4;
  localparam int MIN_ROWS    = 3;

  // Line buffer word: [1:0] upper line pair, [3:2] middle line pair
  localparam int LINE_W = 4;

  // Conversion coefficients, 8.8 fixed point
  localparam int COEF_RU = 454;
  localparam int COEF_GV = 88;
  localparam int COEF_GU = 183;
  localparam int COEF_BV = 359;

  // Register reset values
  localparam logic [PIX_W-1:0]      RST_RED_FLOOR  = 8'd128;
  localparam logic [PIX_W-1:0]      RST_RED_MARGIN = 8'd40;
  localparam logic [CFG_SIZE_W-1:0] RST_COLUMNS    = 11'd320;
  localparam logic [CFG_SIZE_W-1:0] RST_ROWS       = 11'd240;

  typedef enum logic [1:0] {
    REG_RED_FLOOR,
    REG_RED_MARGIN,
    REG_WINDOW_COLUMNS,
    REG_WINDOW_ROWS
  } cfg_reg_t;

endpackage
`default_nettype wire

// ----- sv/yrbc_if.sv -----
// Valid/ready channel interfaces: pixel input, result output, register writes.
`timescale 1ns / 1ps
`default_nettype none
interface yrbc_pix_if;
  import yrbc_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] luma_first;
  logic [PIX_W-1:0] chroma_v;
  logic [PIX_W-1:0] luma_second;
  logic [PIX_W-1:0] chroma_u;
  logic             window_start;

  modport source (output valid, luma_first, chroma_v, luma_second, chroma_u, window_start,
                  input ready);
  modport sink (input valid, luma_first, chroma_v, luma_second, chroma_u, window_start,
                output ready);
endinterface

interface yrbc_res_if;
  import yrbc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] match_count;
  logic [SUM_W-1:0]   column_sum;
  logic [SUM_W-1:0]   row_sum;

  modport source (output valid, match_count, column_sum, row_sum, input ready);
  modport sink (input valid, match_count, column_sum, row_sum, output ready);
endinterface

interface yrbc_cfg_if;
  import yrbc_pkg::*;
  logic                  valid;
  logic                  ready;
  cfg_reg_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/yuyv_red_blob_centroid.sv -----
// Top level: YUYV red mask, 3x3 erosion and centroid sums over a window.
`timescale 1ns / 1ps
`default_nettype none
//
// Channel  Modport  Transfer when        Payload
// -------  -------  -------------------  ------------------------------------------------
// pix      sink     pix.valid&pix.ready  luma_first, chroma_v, luma_second, chroma_u,
//                                        window_start (one macropixel, raster order)
// res      source   res.valid&res.ready  match_count, column_sum, row_sum (end of window)
// cfg      sink     cfg.valid (ready=1)  index (red_floor, red_margin, window_columns,
//                                        window_rows), data
//
// One macropixel a cycle, sustained but for the stall below. A macropixel passes the input register
// (color test), then the line stage (line buffer read, erosion, sums); the
// last macropixel of a window then writes its result to the output register.
// rst clears control, counters, sums and registers; the line buffer is not
// cleared, since its first two rows of a window are never counted.
// Input stalls only while a finished result waits in the output register
// and the last macropixel of the next window reaches the line stage.
//
module yuyv_red_blob_centroid (
  input  wire logic   clk,
  input  wire logic   rst,
  yrbc_pix_if.sink    pix,
  yrbc_res_if.source  res,
  yrbc_cfg_if.sink    cfg
);
  import yrbc_pkg::*;

  // ---------------------------------------------------------------- config
  logic [PIX_W-1:0]      red_floor;
  logic [PIX_W-1:0]      red_margin;
  logic [CFG_SIZE_W-1:0] window_columns;
  logic [CFG_SIZE_W-1:0] window_rows;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_floor      <= RST_RED_FLOOR;
      red_margin     <= RST_RED_MARGIN;
      window_columns <= RST_COLUMNS;
      window_rows    <= RST_ROWS;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_RED_FLOOR:      red_floor      <= cfg.data[PIX_W-1:0];
        REG_RED_MARGIN:     red_margin     <= cfg.data[PIX_W-1:0];
        REG_WINDOW_COLUMNS: window_columns <= cfg.data[CFG_SIZE_W-1:0];
        REG_WINDOW_ROWS:    window_rows    <= cfg.data[CFG_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective window size: clamp columns to 4..MAX and force even, rows to 3..MAX
  logic [SIZE_W-1:0] cols_raw, rows_raw, cols_eff, rows_eff;

  always_comb begin
    cols_raw = SIZE_W'(window_columns);
    rows_raw = SIZE_W'(window_rows);
    if (cols_raw < SIZE_W'(MIN_COLUMNS)) begin
      cols_eff = SIZE_W'(MIN_COLUMNS);
    end else if (cols_raw > SIZE_W'(MAX_COLUMNS)) begin
      cols_eff = SIZE_W'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_raw;
    end
    cols_eff[0] = 1'b0;
    if (rows_raw < SIZE_W'(MIN_ROWS)) begin
      rows_eff = SIZE_W'(MIN_ROWS);
    end else if (rows_raw > SIZE_W'(MAX_ROWS)) begin
      rows_eff = SIZE_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_raw;
    end
  end

  // ------------------------------------------------------------ handshake
  logic s1_valid, s2_valid;
  logic s2_last;
  logic out_valid;
  logic adv;
  logic pix_xfer;

  // Hold the whole pipe only when a second result would overwrite a waiting one
  assign adv      = !(s2_valid && s2_last && out_valid && !res.ready);
  assign pix.ready = adv;
  assign pix_xfer = pix.valid && adv;

  // --------------------------------------------------- position tracking
  logic [COL_W-1:0] col_ctr;
  logic [ROW_W-1:0] row_ctr;
  logic [COL_W-1:0] pos_col;
  logic [ROW_W-1:0] pos_row;
  logic             row_end, win_end;

  always_comb begin
    pos_col = pix.window_start ? '0 : col_ctr;
    pos_row = pix.window_start ? '0 : row_ctr;
    row_end = (SIZE_W'(pos_col) + SIZE_W'(2)) >= cols_eff;
    win_end = row_end && ((SIZE_W'(pos_row) + SIZE_W'(1)) >= rows_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_ctr <= '0;
      row_ctr <= '0;
    end else if (pix_xfer) begin
      if (row_end) begin
        col_ctr <= '0;
        row_ctr <= win_end ? '0 : pos_row + ROW_W'(1);
      end else begin
        col_ctr <= pos_col + COL_W'(2);
        row_ctr <= pos_row;
      end
    end
  end

  // ------------------------------------------------------ input register
  logic [PIX_W-1:0] s1_luma0, s1_luma1, s1_v, s1_u;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_restart, s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_xfer) begin
      s1_luma0   <= pix.luma_first;
      s1_luma1   <= pix.luma_second;
      s1_v       <= pix.chroma_v;
      s1_u       <= pix.chroma_u;
      s1_col     <= pos_col;
      s1_row     <= pos_row;
      s1_restart <= pix.window_start;
      s1_last    <= win_end;
    end
  end

  // ------------------------------------------------------- color test
  // Clamp a scaled channel (8.8) to 0..255 after a floor shift
  function automatic logic [PIX_W-1:0] clamp_chan(input logic signed [18:0] s);
    logic [PIX_W-1:0] c;
    if (s[18]) begin
      c = '0;
    end else if (|s[17:16]) begin
      c = '1;
    end else begin
      c = s[15:8];
    end
    return c;
  endfunction

  function automatic logic red_test(input logic [PIX_W-1:0] y, input logic [PIX_W-1:0] vb,
                                    input logic [PIX_W-1:0] ub, input logic [PIX_W-1:0] floor_v,
                                    input logic [PIX_W-1:0] margin);
    logic signed [18:0] ys, vs, us;
    logic [PIX_W-1:0]   r, g, b;
    logic [PIX_W:0]     g_m, b_m;
    // byte minus 128 is the byte with its top bit flipped, read as signed
    ys  = signed'({3'b000, y, 8'h00});
    vs  = 19'(signed'({~vb[7], vb[6:0]}));
    us  = 19'(signed'({~ub[7], ub[6:0]}));
    r   = clamp_chan(ys + 19'(COEF_RU) * us);
    g   = clamp_chan(ys + 19'(COEF_GV) * vs - 19'(COEF_GU) * us);
    b   = clamp_chan(ys + 19'(COEF_BV) * vs);
    g_m = {1'b0, g} + {1'b0, margin};
    b_m = {1'b0, b} + {1'b0, margin};
    return (r > floor_v) && ({1'b0, r} > g_m) && ({1'b0, r} > b_m);
  endfunction

  logic [1:0] mask_bits;
  assign mask_bits[0] = red_test(s1_luma0, s1_v, s1_u, red_floor, red_margin);
  assign mask_bits[1] = red_test(s1_luma1, s1_v, s1_u, red_floor, red_margin);

  // ---------------------------------------------------------- line buffer
  // One word per column pair: upper and middle mask lines
  logic [LINE_W-1:0] line_mem [LINE_DEPTH];
  logic [LINE_W-1:0] line_q;
  logic [LINE_W-1:0] line_wdata;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_en;

  logic [1:0]       s2_mask;
  logic [COL_W-1:0] s2_col;
  logic [ROW_W-1:0] s2_row;
  logic             s2_restart;

  assign rd_addr    = s1_col[COL_W-1:1];
  assign wr_addr    = s2_col[COL_W-1:1];
  assign wr_en      = s2_valid && adv;
  // shift down: middle becomes upper, new mask becomes middle
  assign line_wdata = {s2_mask, line_q[3:2]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= line_wdata;
    end
    if (adv) begin
      // forward the word being written when a restart revisits the same pair
      line_q <= (wr_en && (wr_addr == rd_addr)) ? line_wdata : line_mem[rd_addr];
    end
  end

  // ----------------------------------------------------------- line stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mask    <= mask_bits;
      s2_col     <= s1_col;
      s2_row     <= s1_row;
      s2_restart <= s1_restart;
      s2_last    <= s1_last;
    end
  end

  // ------------------------------------------------------ erosion and sums
  logic [8:0]         nb;
  logic [8:0]         nb_base, nb_mid, nb_next;
  logic               interior, hit0, hit1;
  logic [COL_W:0]     col_add;
  logic [ROW_W:0]     row_add;
  logic [1:0]         cnt_add;
  logic [COUNT_W-1:0] count_acc, count_next;
  logic [SUM_W-1:0]   column_acc, column_next;
  logic [SUM_W-1:0]   row_acc, row_next;
  logic [ROW_W-1:0]   row_m1;

  always_comb begin
    nb_base  = s2_restart ? '0 : nb;
    // each column enters as {upper, middle, current}
    nb_mid   = {nb_base[5:0], line_q[0], line_q[2], s2_mask[0]};
    nb_next  = {nb_mid[5:0], line_q[1], line_q[3], s2_mask[1]};
    interior = (s2_row >= ROW_W'(2)) && (s2_col >= COL_W'(2));
    hit0     = interior && (&nb_mid);
    hit1     = interior && (&nb_next);
    row_m1   = s2_row - ROW_W'(1);
    // eroded pixel sits one column and one row back from the newest pixel
    col_add  = (hit0 ? {1'b0, s2_col} - (COL_W+1)'(1) : '0) + (hit1 ? {1'b0, s2_col} : '0);
    cnt_add  = {1'b0, hit0} + {1'b0, hit1};
    case (cnt_add)
      2'd1:    row_add = {1'b0, row_m1};
      2'd2:    row_add = {row_m1, 1'b0};
      default: row_add = '0;
    endcase
    count_next  = (s2_restart ? '0 : count_acc) + COUNT_W'(cnt_add);
    column_next = (s2_restart ? '0 : column_acc) + SUM_W'(col_add);
    row_next    = (s2_restart ? '0 : row_acc) + SUM_W'(row_add);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nb         <= '0;
      count_acc  <= '0;
      column_acc <= '0;
      row_acc    <= '0;
    end else if (wr_en) begin
      if (s2_last) begin
        // close the window and restart as after a window_start
        nb         <= '0;
        count_acc  <= '0;
        column_acc <= '0;
        row_acc    <= '0;
      end else begin
        nb         <= nb_next;
        count_acc  <= count_next;
        column_acc <= column_next;
        row_acc    <= row_next;
      end
    end
  end

  // ------------------------------------------------------- output register
  logic [COUNT_W-1:0] res_count;
  logic [SUM_W-1:0]   res_col, res_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr_en && s2_last) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && s2_last) begin
      res_count <= count_next;
      res_col   <= column_next;
      res_row   <= row_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.match_count = res_count;
  assign res.column_sum  = res_col;
  assign res.row_sum     = res_row;

  // ------------------------------------------------------------ assertions
  // A result appears only when the last macropixel of a window leaves the line stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s2_valid && s2_last && adv))
    else $error("result raised without a window end");

  // Closing a window leaves the sums cleared for the next one
  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    (wr_en && s2_last) |=> (count_acc == '0 && column_acc == '0 && row_acc == '0 && nb == '0))
    else $error("sums not cleared after a window end");

  // A read of the pair being written returns the new word
  a_line_forward: assert property (@(posedge clk) disable iff (rst)
    (wr_en && s1_valid && (wr_addr == rd_addr)) |=> (line_q == $past(line_wdata)))
    else $error("line buffer forwarding missed");

  // The column position of a macropixel is always even
  a_even_column: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_col[0] == 1'b0 && col_ctr[0] == 1'b0))
    else $error("odd column position");

endmodule
`default_nettype wire

// ----- dv/yrbc_blob_stats_check.sv -----
// Checker for the red blob centroid block: predicts window totals from the pixel stream.
`timescale 1ns / 1ps
module yrbc_blob_stats_check
  import yrbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  yrbc_pix_if  pix,
  yrbc_res_if  res,
  yrbc_cfg_if  cfg,
  output int   fail_count,
  output int   totals_pending
);

  // 8.8 color conversion weights
  localparam int WEIGHT_R_U = 454;
  localparam int WEIGHT_G_V = 88;
  localparam int WEIGHT_G_U = 183;
  localparam int WEIGHT_B_V = 359;

  localparam logic [7:0]  FLOOR_AT_RESET   = 8'd128;
  localparam logic [7:0]  MARGIN_AT_RESET  = 8'd40;
  localparam logic [10:0] COLUMNS_AT_RESET = 11'd320;
  localparam logic [10:0] ROWS_AT_RESET    = 11'd240;

  typedef struct packed {
    logic [COUNT_W-1:0] match_count;
    logic [SUM_W-1:0]   column_sum;
    logic [SUM_W-1:0]   row_sum;
  } blob_totals_t;

  blob_totals_t          window_totals_q[$];
  blob_totals_t          running_totals;
  blob_totals_t          oldest;
  logic [PIX_W-1:0]      red_floor;
  logic [PIX_W-1:0]      red_margin;
  logic [CFG_SIZE_W-1:0] window_columns;
  logic [CFG_SIZE_W-1:0] window_rows;
  logic                  mask_upper [MAX_COLUMNS];
  logic                  mask_middle [MAX_COLUMNS];
  logic [8:0]            erosion_bits;
  logic [COL_W-1:0]      col_pos;
  logic [ROW_W-1:0]      row_pos;
  int                    errors = 0;

  function automatic int channel_level(int scaled);
    int level;
    level = scaled >>> 8;
    if (level < 0) return 0;
    if (level > 255) return 255;
    return level;
  endfunction

  function automatic bit is_red(logic [PIX_W-1:0] luma, int v, int u);
    int y, r, g, b;
    y = int'(luma) * 256;
    r = channel_level(y + WEIGHT_R_U * u);
    g = channel_level(y + WEIGHT_G_V * v - WEIGHT_G_U * u);
    b = channel_level(y + WEIGHT_B_V * v);
    return r > int'(red_floor) && (r - g) > int'(red_margin) && (r - b) > int'(red_margin);
  endfunction

  function automatic void restart_window();
    erosion_bits   = '0;
    col_pos        = '0;
    row_pos        = '0;
    running_totals = '0;
  endfunction

  // Shift one mask column into the 3x3 window and count its center when all set
  function automatic void erode_pixel(int col, int row, bit hit);
    int c;
    c = col % MAX_COLUMNS;
    erosion_bits   = {erosion_bits[5:0], mask_upper[c], mask_middle[c], hit};
    mask_upper[c]  = mask_middle[c];
    mask_middle[c] = hit;
    if (row >= 2 && col >= 2 && &erosion_bits) begin
      running_totals.match_count = running_totals.match_count + 1'b1;
      running_totals.column_sum  = running_totals.column_sum + SUM_W'(col - 1);
      running_totals.row_sum     = running_totals.row_sum + SUM_W'(row - 1);
    end
  endfunction

  function automatic void take_macropixel(logic [PIX_W-1:0] y0, logic [PIX_W-1:0] cv,
                                          logic [PIX_W-1:0] y1, logic [PIX_W-1:0] cu,
                                          logic start);
    int cols, rows, v, u;
    bit hit0, hit1;
    if (start) restart_window();
    cols = int'(window_columns);
    if (cols < 4) cols = 4;
    if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
    cols = cols - (cols % 2);
    rows = int'(window_rows);
    if (rows < 3) rows = 3;
    if (rows > MAX_ROWS) rows = MAX_ROWS;
    v = int'(cv) - 128;
    u = int'(cu) - 128;
    hit0 = is_red(y0, v, u);
    hit1 = is_red(y1, v, u);
    erode_pixel(int'(col_pos), int'(row_pos), hit0);
    erode_pixel(int'(col_pos) + 1, int'(row_pos), hit1);
    if (int'(col_pos) + 2 >= cols) begin
      col_pos = '0;
      if (int'(row_pos) + 1 >= rows) begin
        window_totals_q.push_back(running_totals);
        restart_window();
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 2'd2;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      red_floor      = FLOOR_AT_RESET;
      red_margin     = MARGIN_AT_RESET;
      window_columns = COLUMNS_AT_RESET;
      window_rows    = ROWS_AT_RESET;
      window_totals_q.delete();
      for (int i = 0; i < MAX_COLUMNS; i++) begin
        mask_upper[i]  = 1'b0;
        mask_middle[i] = 1'b0;
      end
      restart_window();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_RED_FLOOR:      red_floor = cfg.data[PIX_W-1:0];
          REG_RED_MARGIN:     red_margin = cfg.data[PIX_W-1:0];
          REG_WINDOW_COLUMNS: window_columns = cfg.data;
          REG_WINDOW_ROWS:    window_rows = cfg.data;
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (window_totals_q.size() == 0) begin
          errors++;
          $error("match_count: expected no result, actual %0d", res.match_count);
        end else begin
          oldest = window_totals_q.pop_front();
          if (res.match_count !== oldest.match_count) begin
            errors++;
            $error("match_count: expected %0d, actual %0d", oldest.match_count,
                   res.match_count);
          end
          if (res.column_sum !== oldest.column_sum) begin
            errors++;
            $error("column_sum: expected %0d, actual %0d", oldest.column_sum,
                   res.column_sum);
          end
          if (res.row_sum !== oldest.row_sum) begin
            errors++;
            $error("row_sum: expected %0d, actual %0d", oldest.row_sum, res.row_sum);
          end
        end
      end
      if (pix.valid && pix.ready)
        take_macropixel(pix.luma_first, pix.chroma_v, pix.luma_second, pix.chroma_u,
                        pix.window_start);
    end
    fail_count     <= errors;
    totals_pending <= window_totals_q.size();
  end

endmodule

// ----- dv/yuyv_red_blob_centroid_tb.sv -----
// Testbench top for the YUYV red blob centroid block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module yuyv_red_blob_centroid_tb;
  import yrbc_pkg::*;

  // Longest stretch with no transfer on any channel before the run is called hung
  localparam int IDLE_LIMIT        = 5000;
  // Edges to let pass after the last result
  localparam int DRAIN_CYCLES      = 8;
  localparam int SETTINGS_PER_MODE = 4;
  localparam int ITEMS_PER_SETTING = 95;

  logic clk;
  logic rst;
  int   sender_gap_pct = 0;
  int   receiver_stall_pct = 0;
  int   quiet_cycles = 0;
  int   fail_count;
  int   totals_pending;

  // Window size last written, used only to shape whole windows of stimulus
  logic [CFG_SIZE_W-1:0] cur_columns;
  logic [CFG_SIZE_W-1:0] cur_rows;

  yrbc_pix_if pix_ch();
  yrbc_res_if res_ch();
  yrbc_cfg_if cfg_ch();

  yuyv_red_blob_centroid dut (
    .clk (clk),
    .rst (rst),
    .pix (pix_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  yrbc_blob_stats_check blob_check (
    .clk            (clk),
    .rst            (rst),
    .pix            (pix_ch),
    .res            (res_ch),
    .cfg            (cfg_ch),
    .fail_count     (fail_count),
    .totals_pending (totals_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: stall at random at the rate of the current idling mode
  always @(posedge clk) begin
    if (receiver_stall_pct == 0) begin
      res_ch.ready <= 1'b1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Hang detection: count edges with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("yuyv_red_blob_centroid_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Effective window size as the block clamps it
  function automatic int pairs_per_row(logic [CFG_SIZE_W-1:0] cols);
    int c;
    c = int'(cols);
    if (c < 4) c = 4;
    if (c > MAX_COLUMNS) c = MAX_COLUMNS;
    return c / 2;
  endfunction

  function automatic int rows_per_window(logic [CFG_SIZE_W-1:0] rows);
    int r;
    r = int'(rows);
    if (r < 3) r = 3;
    if (r > MAX_ROWS) r = MAX_ROWS;
    return r;
  endfunction

  task automatic set_idling(int gap_pct, int stall_pct);
    sender_gap_pct = gap_pct;
    receiver_stall_pct <= stall_pct;
  endtask

  // Present one register write and hold it until the transfer; leaves valid high
  task automatic write_register(cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (which == REG_WINDOW_COLUMNS) cur_columns = value;
    if (which == REG_WINDOW_ROWS) cur_rows = value;
  endtask

  task automatic program_window(logic [CFG_DATA_W-1:0] floor_v,
                                logic [CFG_DATA_W-1:0] margin_v,
                                logic [CFG_DATA_W-1:0] cols_v,
                                logic [CFG_DATA_W-1:0] rows_v);
    write_register(REG_RED_FLOOR, floor_v);
    write_register(REG_RED_MARGIN, margin_v);
    write_register(REG_WINDOW_COLUMNS, cols_v);
    write_register(REG_WINDOW_ROWS, rows_v);
    cfg_ch.valid <= 1'b0;
  endtask

  // Insert the random gap, then hold one macropixel until its transfer.
  // Valid is only dropped inside a gap, so it never toggles within one step.
  task automatic send_macropixel(logic [7:0] y0, logic [7:0] cv, logic [7:0] y1,
                                 logic [7:0] cu, logic start);
    while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid        <= 1'b1;
    pix_ch.luma_first   <= y0;
    pix_ch.chroma_v     <= cv;
    pix_ch.luma_second  <= y1;
    pix_ch.chroma_u     <= cu;
    pix_ch.window_start <= start;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  // One window in raster order: a red rectangle with holes on a near-gray
  // background, plus some fully random macropixels so every byte value shows
  // up. A clean window starts with window_start and runs to its last item;
  // otherwise it may skip the start flag, restart itself midway, or stop
  // short after stop_at items.
  task automatic send_window(int pairs, int rows, int stop_at, bit clean);
    int         c0, c1, r0, r1, n;
    logic [7:0] y0, y1, cv, cu;
    logic       start;
    c0 = $urandom_range(pairs - 1);
    c1 = $urandom_range(pairs - 1, c0);
    r0 = $urandom_range(rows - 1);
    r1 = $urandom_range(rows - 1, r0);
    n  = 0;
    for (int row = 0; row < rows; row++) begin
      for (int p = 0; p < pairs; p++) begin
        if (n == stop_at) return;
        if ($urandom_range(9) == 0) begin
          y0 = 8'($urandom);
          y1 = 8'($urandom);
          cv = 8'($urandom);
          cu = 8'($urandom);
        end else if (row >= r0 && row <= r1 && p >= c0 && p <= c1 &&
                     $urandom_range(19) != 0) begin
          y0 = 8'($urandom_range(230, 30));
          y1 = 8'($urandom_range(230, 30));
          cv = 8'($urandom_range(110, 50));
          cu = 8'($urandom_range(255, 190));
        end else begin
          y0 = 8'($urandom);
          y1 = 8'($urandom);
          cv = 8'($urandom_range(140, 116));
          cu = 8'($urandom_range(140, 116));
        end
        if (clean) begin
          start = (n == 0);
        end else begin
          start = (n == 0) ? ($urandom_range(3) != 0) : ($urandom_range(199) == 0);
        end
        send_macropixel(y0, cv, y1, cu, start);
        n++;
      end
    end
  endtask

  // Drop valid, wait for every predicted result, then let the pipe go quiet
  task automatic settle();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (totals_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int                    setting, sent, pairs, rows, total, stop_at;
    bit                    last;
    logic [CFG_DATA_W-1:0] floor_v, margin_v;

    rst                 <= 1'b1;
    pix_ch.valid        <= 1'b0;
    pix_ch.luma_first   <= '0;
    pix_ch.chroma_v     <= '0;
    pix_ch.luma_second  <= '0;
    pix_ch.chroma_u     <= '0;
    pix_ch.window_start <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_RED_FLOOR;
    cfg_ch.data         <= '0;
    cur_columns = 11'd320;
    cur_rows    = 11'd240;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, no idling.
    set_idling(0, 0);

    // Sizes below the minimum clamp to 4x3; every pixel strongly red, lumas at
    // both extremes, chroma at 0 and 255.
    program_window(11'd128, 11'd40, 11'd0, 11'd0);
    for (int i = 0; i < 6; i++)
      send_macropixel(i[0] ? 8'd255 : 8'd0, 8'd0, i[0] ? 8'd0 : 8'd255, 8'd255, i == 0);
    // Same window again with the opposite chroma: nothing red, and no start flag
    // since the position already returned to the origin after the result.
    for (int i = 0; i < 6; i++)
      send_macropixel(8'd255, 8'd255, 8'd0, 8'd0, 1'b0);
    settle();

    // Odd width rounds down to 4, one row clamps to three.
    program_window(11'd128, 11'd40, 11'd5, 11'd1);
    for (int i = 0; i < 6; i++)
      send_macropixel(8'd200, 8'd60, 8'd90, 8'd240, i == 0);
    settle();

    // Shrink the window midway: with the position at row 2, column 2, the next
    // macropixel passes the new width and height and closes the window.
    program_window(11'd128, 11'd40, 11'd6, 11'd4);
    for (int i = 0; i < 7; i++)
      send_macropixel(8'd150, 8'd70, 8'd180, 8'd230, i == 0);
    settle();
    write_register(REG_WINDOW_COLUMNS, 11'd4);
    write_register(REG_WINDOW_ROWS, 11'd3);
    cfg_ch.valid <= 1'b0;
    send_macropixel(8'd150, 8'd70, 8'd180, 8'd230, 1'b0);
    settle();

    // Random part: four idling modes, several register settings in each.
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       set_idling(0, 0);
        1:       set_idling(76, 0);
        2:       set_idling(0, 76);
        default: set_idling(31, 31);
      endcase
      for (int s = 0; s < SETTINGS_PER_MODE; s++) begin
        setting = mode * SETTINGS_PER_MODE + s;
        if (setting % 4 == 1) begin
          floor_v  = '0;
          margin_v = '0;
        end else if (setting % 4 == 2) begin
          floor_v  = '1;
          margin_v = '1;
        end else begin
          floor_v  = {3'($urandom), 8'($urandom_range(200, 60))};
          margin_v = {3'($urandom), 8'($urandom_range(80, 10))};
        end
        program_window(floor_v, margin_v, 11'($urandom_range(24)), 11'($urandom_range(8)));
        sent = 0;
        while (sent < ITEMS_PER_SETTING) begin
          pairs   = pairs_per_row(cur_columns);
          rows    = rows_per_window(cur_rows);
          total   = pairs * rows;
          last    = (sent + total >= ITEMS_PER_SETTING);
          stop_at = (!last && $urandom_range(9) == 0) ? $urandom_range(total - 1, 1) : total;
          send_window(pairs, rows, stop_at, last);
          sent += stop_at;
        end
        settle();
      end
    end

    if (fail_count == 0) begin
      $display("yuyv_red_blob_centroid_tb: done, clean");
    end else begin
      $display("yuyv_red_blob_centroid_tb: done, errors");
    end
    $finish;
  end

endmodule
